### rtl/sgsc_pkg.sv
// Shared types and constants of the servo gripper slew controller.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package sgsc_pkg;

    // Command codes carried in s_tuser
    localparam logic [3:0] CMD_TICK        = 4'd0;
    localparam logic [3:0] CMD_MOVE_TO     = 4'd1;
    localparam logic [3:0] CMD_OPEN        = 4'd2;
    localparam logic [3:0] CMD_CLOSE       = 4'd3;
    localparam logic [3:0] CMD_STOP        = 4'd4;
    localparam logic [3:0] CMD_ESTOP       = 4'd5;
    localparam logic [3:0] CMD_CLEAR_ESTOP = 4'd6;
    localparam logic [3:0] CMD_ATTACH      = 4'd7;
    localparam logic [3:0] CMD_DETACH      = 4'd8;
    localparam logic [3:0] CMD_BEGIN       = 4'd9;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MIN_ANGLE   = 3'd0;
    localparam logic [2:0] REG_MAX_ANGLE   = 3'd1;
    localparam logic [2:0] REG_MIN_PULSE   = 3'd2;
    localparam logic [2:0] REG_MAX_PULSE   = 3'd3;
    localparam logic [2:0] REG_SLEW_SPEED  = 3'd4;
    localparam logic [2:0] REG_OPEN_ANGLE  = 3'd5;
    localparam logic [2:0] REG_CLOSE_ANGLE = 3'd6;
    localparam logic [2:0] REG_HOME_ANGLE  = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_MIN_ANGLE   = 16'd0;
    localparam logic [15:0] RST_MAX_ANGLE   = 16'd46080;
    localparam logic [11:0] RST_MIN_PULSE   = 12'd500;
    localparam logic [11:0] RST_MAX_PULSE   = 12'd2500;
    localparam logic [17:0] RST_SLEW_SPEED  = 18'd23040;
    localparam logic [15:0] RST_OPEN_ANGLE  = 16'd23040;
    localparam logic [15:0] RST_CLOSE_ANGLE = 16'd0;
    localparam logic [15:0] RST_HOME_ANGLE  = 16'd23040;

    localparam int DT_LIMIT  = 500;
    localparam int SPEED_DIV = 1000;

    // Serial divider sizes: numerator and divisor widths
    localparam int DIV_W = 30;
    localparam int DEN_W = 17;
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP_MUL,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_MAP_MUL,
        ST_MAP_GO,
        ST_MAP_WAIT,
        ST_FINISH
    } state_t;

    function automatic logic [15:0] clamp_angle(input logic [15:0] a,
                                                input logic [15:0] lo,
                                                input logic [15:0] hi);
        if (a < lo) begin
            return lo;
        end else if (a > hi) begin
            return hi;
        end else begin
            return a;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/sgsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sgsc_pkg for the operand widths.
`default_nettype none

module sgsc_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [sgsc_pkg::DIV_W-1:0] num,
    input  wire logic [sgsc_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic [sgsc_pkg::DIV_W-1:0]      quot
);
    import sgsc_pkg::*;

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] qs_reg, qs_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Shift the next numerator bit into the remainder and try a subtract
    always_comb begin
        trial    = {rem_reg, qs_reg[DIV_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        qs_next  = {qs_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            qs_reg  <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            qs_reg  <= qs_next;
        end
    end

    assign done = done_reg;
    assign quot = qs_reg;

endmodule

`default_nettype wire

### rtl/servo_gripper_slew_controller.sv
// Top level of the servo gripper slew controller: register file, command
// sequencer and result register. Depends on sgsc_pkg and sgsc_div.
`default_nettype none

// Usage:
// Commands enter on the s_ channel, one transaction per command: s_tuser
// holds the command code, s_tdata the goal angle and millisecond time.
// Each command yields exactly one result transaction on the m_ channel with
// the angle, target, pulse width and status flags after that command.
// Registers are to be written through the APB-style port only while the block
// is idle; the block itself does not enforce this. A command's result waits
// on the shared bit-serial divider: on a tick that moves the servo one
// division scales the slew step by 1000, and for every command a second
// maps the angle to a rounded pulse width, unless the angle span is empty.
// One command is in work at a time; s_tready rises again as soon as the
// result is loaded into the output register, so the next command can be
// accepted while the result still waits for m_tready.
// A stalled receiver holds the result steady and, once the next command
// is finished, holds the sequencer in its last state until the output
// register frees up.
// Reset (aresetn low, synchronous) restores register defaults, puts angle
// and target at the home angle, detaches the servo, clears the emergency
// stop and marks the last pulse as unsent.
module servo_gripper_slew_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: goal_angle[15:0], now_ms[47:16]
    input  wire logic [47:0] s_tdata,
    // s_tuser: command[3:0]
    input  wire logic [3:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: position[15:0], goal[31:16], pulse_us[43:32], pulse_write[44],
    //          is_attached[45], is_moving[46], estop_active[47]
    output logic [47:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sgsc_pkg::*;

    // Configuration registers
    logic [15:0] min_angle_reg, max_angle_reg, open_angle_reg;
    logic [15:0] close_angle_reg, home_angle_reg;
    logic [11:0] min_pulse_reg, max_pulse_reg;
    logic [17:0] slew_speed_reg;

    // Controller state
    state_t      state_reg, state_next;
    logic [15:0] cur_reg, tgt_reg;
    logic [11:0] last_pulse_reg;
    logic        last_valid_reg;
    logic [31:0] last_time_reg;
    logic        att_reg, estop_reg;

    // Captured command
    logic [3:0]  cmd_reg;
    logic [15:0] goal_in_reg;
    logic [31:0] now_reg;

    // Datapath registers
    logic [8:0]  dtc_reg;
    logic [26:0] step_prod_reg;
    logic [27:0] map_prod_reg;
    logic [15:0] span_reg;
    logic        pneg_reg;
    logic [11:0] pulse_reg;

    // Output register
    logic [47:0] m_tdata_reg;
    logic        m_tvalid_reg;

    logic              cfg_wr;
    logic              s_acc;
    logic              out_free;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_num, div_quot;
    logic [DEN_W-1:0]  div_den;
    logic [31:0]       dt;
    logic [8:0]        dtc;
    logic              motion;
    logic [15:0]       gap;
    logic [15:0]       d_clamped, off;
    logic [11:0]       pmag;
    logic              pneg, span_empty;
    logic [29:0]       a2, span30;
    logic [29:0]       map_num;
    logic              pulse_check, wrote;
    logic [15:0]       home_clamped;

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- register file ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg   <= RST_MIN_ANGLE;
            max_angle_reg   <= RST_MAX_ANGLE;
            min_pulse_reg   <= RST_MIN_PULSE;
            max_pulse_reg   <= RST_MAX_PULSE;
            slew_speed_reg  <= RST_SLEW_SPEED;
            open_angle_reg  <= RST_OPEN_ANGLE;
            close_angle_reg <= RST_CLOSE_ANGLE;
            home_angle_reg  <= RST_HOME_ANGLE;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MIN_ANGLE:   min_angle_reg   <= pwdata[15:0];
                REG_MAX_ANGLE:   max_angle_reg   <= pwdata[15:0];
                REG_MIN_PULSE:   min_pulse_reg   <= pwdata[11:0];
                REG_MAX_PULSE:   max_pulse_reg   <= pwdata[11:0];
                REG_SLEW_SPEED:  slew_speed_reg  <= pwdata[17:0];
                REG_OPEN_ANGLE:  open_angle_reg  <= pwdata[15:0];
                REG_CLOSE_ANGLE: close_angle_reg <= pwdata[15:0];
                REG_HOME_ANGLE:  home_angle_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MIN_ANGLE:   prdata = {16'd0, min_angle_reg};
            REG_MAX_ANGLE:   prdata = {16'd0, max_angle_reg};
            REG_MIN_PULSE:   prdata = {20'd0, min_pulse_reg};
            REG_MAX_PULSE:   prdata = {20'd0, max_pulse_reg};
            REG_SLEW_SPEED:  prdata = {14'd0, slew_speed_reg};
            REG_OPEN_ANGLE:  prdata = {16'd0, open_angle_reg};
            REG_CLOSE_ANGLE: prdata = {16'd0, close_angle_reg};
            REG_HOME_ANGLE:  prdata = {16'd0, home_angle_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------- combinational datapath ----------------
    always_comb begin
        // Elapsed time wraps modulo 2^32; limit it to the maximum step window
        dt     = now_reg - last_time_reg;
        dtc    = (dt > 32'(DT_LIMIT)) ? 9'(DT_LIMIT) : dt[8:0];
        motion = att_reg && (tgt_reg != cur_reg) && (dt != 32'd0);
        gap    = (tgt_reg > cur_reg) ? tgt_reg - cur_reg : cur_reg - tgt_reg;

        home_clamped = clamp_angle(home_angle_reg, min_angle_reg, max_angle_reg);

        // Angle to pulse mapping operands
        span_empty = min_angle_reg >= max_angle_reg;
        d_clamped  = clamp_angle(cur_reg, min_angle_reg, max_angle_reg);
        off        = d_clamped - min_angle_reg;
        pneg       = max_pulse_reg < min_pulse_reg;
        pmag       = pneg ? min_pulse_reg - max_pulse_reg : max_pulse_reg - min_pulse_reg;

        // Add half a step, then truncate toward zero on the result sign
        a2     = {1'b0, map_prod_reg, 1'b0};
        span30 = {14'd0, span_reg};
        if (!pneg_reg) begin
            map_num = a2 + span30;
        end else if (a2 > span30) begin
            map_num = a2 - span30;
        end else begin
            map_num = '0;
        end

        pulse_check = att_reg && ((cmd_reg == CMD_TICK) || (cmd_reg == CMD_ATTACH) ||
                                  (cmd_reg == CMD_BEGIN));
        wrote       = pulse_check && (!last_valid_reg || (pulse_reg != last_pulse_reg));
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_acc) state_next = ST_EXEC;
            ST_EXEC:      state_next = (cmd_reg == CMD_TICK && motion) ? ST_STEP_MUL
                                                                       : ST_MAP_MUL;
            ST_STEP_MUL:  state_next = ST_STEP_GO;
            ST_STEP_GO:   state_next = ST_STEP_WAIT;
            ST_STEP_WAIT: if (div_done) state_next = ST_MAP_MUL;
            ST_MAP_MUL:   state_next = span_empty ? ST_FINISH : ST_MAP_GO;
            ST_MAP_GO:    state_next = ST_MAP_WAIT;
            ST_MAP_WAIT:  if (div_done) state_next = ST_FINISH;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_num   = map_num;
        div_den   = {span_reg, 1'b0};
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_STEP_GO: begin
                div_start = 1'b1;
                div_num   = DIV_W'(step_prod_reg);
                div_den   = DEN_W'(SPEED_DIV);
            end
            ST_MAP_GO:  div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- controller state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= RST_HOME_ANGLE;
            tgt_reg        <= RST_HOME_ANGLE;
            last_pulse_reg <= '0;
            last_valid_reg <= 1'b0;
            last_time_reg  <= '0;
            att_reg        <= 1'b0;
            estop_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_EXEC: begin
                    case (cmd_reg)
                        CMD_TICK: last_time_reg <= now_reg;
                        CMD_MOVE_TO: if (att_reg && !estop_reg)
                            tgt_reg <= clamp_angle(goal_in_reg, min_angle_reg, max_angle_reg);
                        CMD_OPEN: if (att_reg && !estop_reg)
                            tgt_reg <= clamp_angle(open_angle_reg, min_angle_reg, max_angle_reg);
                        CMD_CLOSE: if (att_reg && !estop_reg)
                            tgt_reg <= clamp_angle(close_angle_reg, min_angle_reg, max_angle_reg);
                        CMD_STOP: tgt_reg <= cur_reg;
                        CMD_ESTOP: begin
                            estop_reg <= 1'b1;
                            tgt_reg   <= cur_reg;
                        end
                        CMD_CLEAR_ESTOP: estop_reg <= 1'b0;
                        CMD_ATTACH: if (!att_reg) begin
                            att_reg        <= 1'b1;
                            last_valid_reg <= 1'b0;
                            last_time_reg  <= now_reg;
                        end
                        CMD_DETACH: begin
                            att_reg <= 1'b0;
                            tgt_reg <= cur_reg;
                        end
                        CMD_BEGIN: begin
                            cur_reg       <= home_clamped;
                            tgt_reg       <= home_clamped;
                            last_time_reg <= now_reg;
                            if (!att_reg) begin
                                att_reg        <= 1'b1;
                                last_valid_reg <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_STEP_WAIT: if (div_done) begin
                    // Land on the target when the step covers the distance
                    if (div_quot >= DIV_W'(gap)) begin
                        cur_reg <= tgt_reg;
                    end else if (tgt_reg > cur_reg) begin
                        cur_reg <= cur_reg + div_quot[15:0];
                    end else begin
                        cur_reg <= cur_reg - div_quot[15:0];
                    end
                end
                ST_FINISH: if (out_free && wrote) begin
                    last_pulse_reg <= pulse_reg;
                    last_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg     <= s_tuser;
            goal_in_reg <= s_tdata[15:0];
            now_reg     <= s_tdata[47:16];
        end
        if (state_reg == ST_EXEC) begin
            dtc_reg <= dtc;
        end
        if (state_reg == ST_STEP_MUL) begin
            step_prod_reg <= 27'(slew_speed_reg) * 27'(dtc_reg);
        end
        if (state_reg == ST_MAP_MUL) begin
            map_prod_reg <= 28'(off) * 28'(pmag);
            span_reg     <= max_angle_reg - min_angle_reg;
            pneg_reg     <= pneg;
            if (span_empty) begin
                pulse_reg <= 12'(({1'b0, min_pulse_reg} + {1'b0, max_pulse_reg}) >> 1);
            end
        end
        if (state_reg == ST_MAP_WAIT && div_done) begin
            pulse_reg <= pneg_reg ? min_pulse_reg - div_quot[11:0]
                                  : min_pulse_reg + div_quot[11:0];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= {estop_reg, (tgt_reg != cur_reg), att_reg, wrote,
                            pulse_reg, tgt_reg, cur_reg};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    sgsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

`ifndef SYNTHESIS
    // A result never asks for a pulse write on a detached servo
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[44] || m_tdata[45]))
        else $error("pulse write reported while detached");

    // The moving flag agrees with the reported angle and target
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[46] == (m_tdata[31:16] != m_tdata[15:0])))
        else $error("moving flag disagrees with position and goal");

    // An accepted command closes the input until its result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened before command finished");

    // The divider only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_STEP_WAIT || state_reg == ST_MAP_WAIT))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

### bench/sgsc_checker.sv
// Checker for the servo gripper slew controller: mirrors register writes,
// predicts one result per accepted command and compares. Depends on sgsc_pkg.
`timescale 1ns / 1ps

module sgsc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [47:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    import sgsc_pkg::*;

    logic [15:0] lo_ang, hi_ang, open_ang, close_ang, home_ang;
    logic [11:0] lo_pw, hi_pw;
    logic [17:0] speed;
    logic [15:0] cur_ang, tgt_ang;
    logic [11:0] sent_pw;
    logic        sent_ok, attached, estop;
    logic [31:0] stamp;
    logic [47:0] result_q[$];

    function automatic logic [15:0] limit_angle(logic [15:0] a);
        if (a < lo_ang) return lo_ang;
        if (a > hi_ang) return hi_ang;
        return a;
    endfunction

    function automatic logic [11:0] angle_pulse(logic [15:0] a);
        longint span, num, q, d;
        if (lo_ang >= hi_ang) return 12'((int'(lo_pw) + int'(hi_pw)) / 2);
        d = longint'(limit_angle(a));
        span = longint'(hi_ang) - longint'(lo_ang);
        num = (d - longint'(lo_ang)) * (longint'(hi_pw) - longint'(lo_pw));
        q = (2 * num + span) / (2 * span);
        return 12'(longint'(lo_pw) + q);
    endfunction

    function automatic logic pulse_check();
        logic [11:0] p;
        if (!attached) return 1'b0;
        p = angle_pulse(cur_ang);
        if (!sent_ok || p != sent_pw) begin
            sent_pw = p;
            sent_ok = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic attach_servo(logic [31:0] now);
        if (!attached) begin
            attached = 1'b1;
            sent_ok = 1'b0;
            stamp = now;
        end
        return pulse_check();
    endfunction

    function automatic logic slew_tick(logic [31:0] now);
        logic [31:0] dt;
        longint step, gap;
        if (!attached) begin
            stamp = now;
            return 1'b0;
        end
        if (tgt_ang != cur_ang) begin
            dt = now - stamp;
            stamp = now;
            if (dt > 0) begin
                if (dt > DT_LIMIT) dt = DT_LIMIT;
                step = (longint'(speed) * longint'(dt)) / SPEED_DIV;
                gap = (tgt_ang > cur_ang) ? longint'(tgt_ang - cur_ang)
                                          : longint'(cur_ang - tgt_ang);
                if (step >= gap) cur_ang = tgt_ang;
                else if (tgt_ang > cur_ang) cur_ang = cur_ang + 16'(step);
                else cur_ang = cur_ang - 16'(step);
            end
        end else begin
            stamp = now;
        end
        return pulse_check();
    endfunction

    function automatic logic [47:0] predict_result(logic [3:0] cmd,
                                                   logic [15:0] req,
                                                   logic [31:0] now);
        logic wr;
        wr = 1'b0;
        case (cmd)
            CMD_TICK:        wr = slew_tick(now);
            CMD_MOVE_TO:     if (!estop && attached) tgt_ang = limit_angle(req);
            CMD_OPEN:        if (!estop && attached) tgt_ang = limit_angle(open_ang);
            CMD_CLOSE:       if (!estop && attached) tgt_ang = limit_angle(close_ang);
            CMD_STOP:        tgt_ang = cur_ang;
            CMD_ESTOP: begin
                estop = 1'b1;
                tgt_ang = cur_ang;
            end
            CMD_CLEAR_ESTOP: estop = 1'b0;
            CMD_ATTACH:      wr = attach_servo(now);
            CMD_DETACH: begin
                attached = 1'b0;
                tgt_ang = cur_ang;
            end
            CMD_BEGIN: begin
                cur_ang = limit_angle(home_ang);
                tgt_ang = cur_ang;
                stamp = now;
                wr = attach_servo(now);
            end
            default: ;
        endcase
        return {estop, tgt_ang != cur_ang, attached, wr, angle_pulse(cur_ang),
                tgt_ang, cur_ang};
    endfunction

    assign pending = result_q.size();

    always @(posedge aclk) begin
        logic [47:0] want;
        if (!aresetn) begin
            lo_ang    <= RST_MIN_ANGLE;
            hi_ang    <= RST_MAX_ANGLE;
            lo_pw     <= RST_MIN_PULSE;
            hi_pw     <= RST_MAX_PULSE;
            speed     <= RST_SLEW_SPEED;
            open_ang  <= RST_OPEN_ANGLE;
            close_ang <= RST_CLOSE_ANGLE;
            home_ang  <= RST_HOME_ANGLE;
            cur_ang   <= RST_HOME_ANGLE;
            tgt_ang   <= RST_HOME_ANGLE;
            sent_pw   <= '0;
            sent_ok   <= 1'b0;
            attached  <= 1'b0;
            estop     <= 1'b0;
            stamp     <= '0;
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_MIN_ANGLE:   lo_ang    = pwdata[15:0];
                    REG_MAX_ANGLE:   hi_ang    = pwdata[15:0];
                    REG_MIN_PULSE:   lo_pw     = pwdata[11:0];
                    REG_MAX_PULSE:   hi_pw     = pwdata[11:0];
                    REG_SLEW_SPEED:  speed     = pwdata[17:0];
                    REG_OPEN_ANGLE:  open_ang  = pwdata[15:0];
                    REG_CLOSE_ANGLE: close_ang = pwdata[15:0];
                    REG_HOME_ANGLE:  home_ang  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                result_q.push_back(predict_result(s_tuser, s_tdata[15:0],
                                                  s_tdata[47:16]));
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    want = result_q.pop_front();
                    if (want !== m_tdata) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h actual %h", want, m_tdata);
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

### bench/tb_top.sv
// Top of the servo gripper controller bench: clock, reset, command and
// register stimulus, verdict. Depends on sgsc_pkg, sgsc_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import sgsc_pkg::*;

    logic        aclk, aresetn;
    logic [47:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        s_tvalid, s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid, m_tready;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          fail_count, pending;
    logic [31:0] clock_ms;
    bit          hold_off;

    servo_gripper_slew_controller dut (.*);

    sgsc_checker chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Receiver: stall on its own pattern; one long hold-off forces the
    // block to fill up and back-pressure the command channel.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Send one command transaction and hold it until accepted; the caller
    // drops s_tvalid when it pauses.
    task automatic send_cmd(logic [3:0] cmd, logic [15:0] req, logic [31:0] now);
        s_tuser  <= cmd;
        s_tdata  <= {now, req};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Pick a plausible time step: mostly small, sometimes huge or wrapping.
    task automatic advance_clock();
        case ($urandom_range(0, 9))
            0:       clock_ms = clock_ms;
            1:       clock_ms = clock_ms + $urandom_range(500, 5000);
            2:       clock_ms = $urandom();
            default: clock_ms = clock_ms + $urandom_range(1, 120);
        endcase
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Let every result drain, then wait out any trailing work.
    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic random_cmd();
        logic [3:0] cmd;
        int pick;
        pick = $urandom_range(0, 99);
        // Favor ticks and moves so the slew path is exercised.
        if (pick < 40) cmd = CMD_TICK;
        else if (pick < 55) cmd = CMD_MOVE_TO;
        else if (pick < 62) cmd = CMD_OPEN;
        else if (pick < 69) cmd = CMD_CLOSE;
        else if (pick < 73) cmd = CMD_STOP;
        else if (pick < 76) cmd = CMD_ESTOP;
        else if (pick < 81) cmd = CMD_CLEAR_ESTOP;
        else if (pick < 86) cmd = CMD_ATTACH;
        else if (pick < 89) cmd = CMD_DETACH;
        else if (pick < 94) cmd = CMD_BEGIN;
        else cmd = 4'($urandom_range(10, 15));
        advance_clock();
        send_cmd(cmd, 16'($urandom()), clock_ms);
    endtask

    // Run a burst-shaped random phase of n commands; always idle at the end.
    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                random_cmd();
                burst--;
                n--;
            end
            if (n == 0 || $urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 50)) @(posedge aclk);
            end
        end
    endtask

    task automatic config_phase(logic [15:0] lo, logic [15:0] hi, logic [11:0] plo,
                                logic [11:0] phi, logic [17:0] spd, logic [15:0] op,
                                logic [15:0] cl, logic [15:0] hm);
        drain();
        reg_write(REG_MIN_ANGLE, 32'(lo));
        reg_write(REG_MAX_ANGLE, 32'(hi));
        reg_write(REG_MIN_PULSE, 32'(plo));
        reg_write(REG_MAX_PULSE, 32'(phi));
        reg_write(REG_SLEW_SPEED, 32'(spd));
        reg_write(REG_OPEN_ANGLE, 32'(op));
        reg_write(REG_CLOSE_ANGLE, 32'(cl));
        reg_write(REG_HOME_ANGLE, 32'(hm));
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_TICK;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_off = 1'b0;
        clock_ms = 32'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: detached tick, every command, extremes, wraparound time.
        send_cmd(CMD_TICK, 16'h0000, 32'd10);
        send_cmd(CMD_MOVE_TO, 16'hFFFF, 32'd20);
        send_cmd(CMD_BEGIN, 16'h0000, 32'd30);
        send_cmd(CMD_ATTACH, 16'h0000, 32'd31);
        send_cmd(CMD_MOVE_TO, 16'hFFFF, 32'd40);
        send_cmd(CMD_TICK, 16'h0000, 32'd40);
        send_cmd(CMD_TICK, 16'h0000, 32'd41);
        send_cmd(CMD_TICK, 16'h0000, 32'd9000);
        send_cmd(CMD_TICK, 16'h0000, 32'd9500);
        send_cmd(CMD_TICK, 16'h0000, 32'd9600);
        send_cmd(CMD_CLOSE, 16'h0000, 32'd9601);
        send_cmd(CMD_TICK, 16'h0000, 32'hFFFF_FFF0);
        send_cmd(CMD_STOP, 16'h0000, 32'hFFFF_FFF1);
        send_cmd(CMD_OPEN, 16'h0000, 32'hFFFF_FFF2);
        send_cmd(CMD_ESTOP, 16'h0000, 32'hFFFF_FFF3);
        send_cmd(CMD_MOVE_TO, 16'h0000, 32'hFFFF_FFF4);
        send_cmd(CMD_CLEAR_ESTOP, 16'h0000, 32'hFFFF_FFF5);
        send_cmd(CMD_MOVE_TO, 16'h0000, 32'hFFFF_FFF6);
        send_cmd(CMD_TICK, 16'h0000, 32'h0000_0100);
        send_cmd(CMD_DETACH, 16'h0000, 32'h0000_0101);
        send_cmd(CMD_TICK, 16'h0000, 32'h0000_0200);
        send_cmd(4'd15, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(4'd10, 16'h5555, 32'hAAAA_AAAA);
        clock_ms = 32'h0000_0300;

        // Long receiver hold-off while commands keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_phase(20);
        join
        random_phase(100);

        // Empty angle span, reversed pulse limits, max speed.
        config_phase(16'd30000, 16'd20000, 12'd4095, 12'd0, 18'h3FFFF, 16'd0,
                     16'hFFFF, 16'hFFFF);
        random_phase(60);
        // Reversed pulses over a wide span, zero speed.
        config_phase(16'd100, 16'd46080, 12'd4095, 12'd0, 18'd0, 16'd46080,
                     16'd100, 16'd0);
        random_phase(40);
        // Extreme limits, odd speed.
        config_phase(16'd0, 16'hFFFF, 12'd0, 12'd4095, 18'd777, 16'd65535,
                     16'd0, 16'd46080);
        random_phase(120);
        // Equal limits and random settings.
        config_phase(16'd12345, 16'd12345, 12'd1, 12'd4094, 18'd1000, 16'd5, 16'd50000,
                     16'd12345);
        random_phase(40);
        config_phase(16'($urandom_range(0, 20000)), 16'($urandom_range(20001, 46080)),
                     12'($urandom()), 12'($urandom()), 18'($urandom()),
                     16'($urandom_range(0, 46080)), 16'($urandom_range(0, 46080)),
                     16'($urandom_range(0, 46080)));
        random_phase(120);

        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
